>>> rtl/ilt_pkg.sv
// Shared types, codes and sizes for the INI line tokenizer.
package ilt_pkg;

  localparam int SPACE_HOLD_DEPTH = 16;
  localparam int LINE_NUMBER_BITS = 24;

  localparam int HOLD_IDX_W = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam int HOLD_CNT_W = $clog2(SPACE_HOLD_DEPTH + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_STOP_ON_GARBAGE = 1'b0;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SECTION = 2'd0;
  localparam kind_t KIND_KEY     = 2'd1;
  localparam kind_t KIND_VALUE   = 2'd2;
  localparam kind_t KIND_STATUS  = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_SKIPPED  = 3'd0;
  localparam status_t ST_SECTION  = 3'd1;
  localparam status_t ST_KEY_VAL  = 3'd2;
  localparam status_t ST_GARBAGE  = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  // At most one command per accepted byte: optional hold write, then flush of held
  // whitespace, then at most one text byte, then at most one line status.
  typedef struct packed {
    logic                        hold_v;
    logic [HOLD_IDX_W-1:0]       hold_idx;
    logic [HOLD_CNT_W-1:0]       flush_n;
    kind_t                       flush_kind;
    logic                        emit_v;
    kind_t                       emit_kind;
    logic [7:0]                  text;
    logic                        status_v;
    status_t                     status;
    logic [LINE_NUMBER_BITS-1:0] line_num;
  } cmd_t;

endpackage

>>> rtl/ini_line_tokenizer_top.sv
// A byte's command passes through the command queue and the sequencer into the output register.
// Throughput: one byte per cycle while each byte gives at most one result and out_ready
//   stays high; a byte that flushes n held whitespace bytes gives n+1 or n+2 results,
//   and the 4-entry command queue absorbs that until it fills, then in_ready drops.
// Reset (rst_n low, synchronous): line phase, counters, queue and output valid clear;
//   stop_on_garbage returns to 1; the whitespace hold buffer is not cleared.
module ini_line_tokenizer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_text_byte,
  input  logic                                 in_end_of_input,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_kind,
  output logic [7:0]                           out_data_byte,
  output logic [2:0]                           out_line_status,
  output logic [ilt_pkg::LINE_NUMBER_BITS-1:0] out_line_number,
  output logic                                 out_last_of_run,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ilt_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [ilt_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [ilt_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);
  import ilt_pkg::*;

  logic stop_on_garbage_r;
  logic cfg_hit;
  logic fifo_push;
  logic fifo_full;
  logic fifo_pop;
  logic fifo_empty;
  cmd_t push_cmd;
  cmd_t fifo_head;

  // word-aligned decode: byte offset bits are ignored
  assign cfg_hit    = cfg_paddr[CFG_ADDR_W-1:2] == CFG_IDX_STOP_ON_GARBAGE;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? {{(CFG_DATA_W-1){1'b0}}, stop_on_garbage_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_on_garbage_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      stop_on_garbage_r <= cfg_pwdata[0];
    end
  end

  ilt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_input (in_end_of_input),
    .stop_on_garbage (stop_on_garbage_r),
    .fifo_full       (fifo_full),
    .push            (fifo_push),
    .push_cmd        (push_cmd)
  );

  ilt_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .head     (fifo_head),
    .empty    (fifo_empty)
  );

  ilt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_empty      (fifo_empty),
    .fifo_head       (fifo_head),
    .fifo_pop        (fifo_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_line_status (out_line_status),
    .out_line_number (out_line_number),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> rtl/ilt_front.sv
// Front end: accepts text bytes, tracks the line phase and issues commands.
module ilt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_text_byte,
  input  logic          in_end_of_input,
  input  logic          stop_on_garbage,
  input  logic          fifo_full,
  output logic          push,
  output ilt_pkg::cmd_t push_cmd
);
  import ilt_pkg::*;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [3:0] {
    PH_LINE_START,
    PH_SKIP,
    PH_SECTION,
    PH_SECTION_DONE,
    PH_KEY,
    PH_VALUE_START,
    PH_VALUE,
    PH_GARBAGE,
    PH_OVERFLOW,
    PH_HALTED
  } phase_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic logic is_key_garbage(input logic [7:0] b);
    return b == CH_COMMA || b == CH_BAR || b == CH_SLASH || b == CH_BSLASH;
  endfunction

  phase_t                      phase_r, phase_nxt;
  logic [HOLD_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [LINE_NUMBER_BITS-1:0] line_r, line_nxt;
  cmd_t                        cmd;
  logic                        accept;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_t                      mid;
    logic                        ws;
    logic                        do_hold;
    logic                        do_flush;
    logic [7:0]                  b;
    logic [LINE_NUMBER_BITS-1:0] ln;
    status_t                     st;

    b         = in_text_byte;
    ws        = is_ws(b);
    do_hold   = 1'b0;
    do_flush  = 1'b0;
    mid       = phase_r;
    cnt_nxt   = cnt_r;
    line_nxt  = line_r;
    phase_nxt = phase_r;
    st        = ST_SKIPPED;
    ln        = line_r;
    cmd       = '0;
    cmd.text  = b;

    if (phase_r != PH_HALTED) begin
      if (b != CH_LF) begin
        unique case (phase_r)
          PH_LINE_START: begin
            if (!ws) begin
              if (b == CH_SEMI || b == CH_HASH) begin
                mid = PH_SKIP;
              end else if (b == CH_LBRACK) begin
                mid = PH_SECTION;
              end else if (b == CH_EQ) begin
                mid = PH_VALUE_START;
              end else if (is_key_garbage(b)) begin
                mid = PH_GARBAGE;
              end else begin
                cmd.emit_v    = 1'b1;
                cmd.emit_kind = KIND_KEY;
                mid           = PH_KEY;
              end
            end
          end
          PH_SECTION: begin
            if (b == CH_RBRACK) begin
              mid = PH_SECTION_DONE;
            end else begin
              cmd.emit_v    = 1'b1;
              cmd.emit_kind = KIND_SECTION;
            end
          end
          PH_KEY: begin
            if (b == CH_EQ) begin
              cnt_nxt = '0;
              mid     = PH_VALUE_START;
            end else if (is_key_garbage(b)) begin
              cnt_nxt = '0;
              mid     = PH_GARBAGE;
            end else if (ws) begin
              do_hold = 1'b1;
            end else begin
              do_flush = 1'b1;
            end
          end
          PH_VALUE_START: begin
            if (!ws) begin
              cmd.emit_v    = 1'b1;
              cmd.emit_kind = KIND_VALUE;
              mid           = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (ws) begin
              do_hold = 1'b1;
            end else begin
              do_flush = 1'b1;
            end
          end
          default: ;
        endcase

        // held whitespace goes out ahead of the text byte that ends the run
        if (do_flush) begin
          cmd.flush_n    = cnt_r;
          cmd.flush_kind = (phase_r == PH_KEY) ? KIND_KEY : KIND_VALUE;
          cmd.emit_v     = 1'b1;
          cmd.emit_kind  = (phase_r == PH_KEY) ? KIND_KEY : KIND_VALUE;
          cnt_nxt        = '0;
        end

        // a full hold buffer drops the run and the rest of the line
        if (do_hold) begin
          if (cnt_r == HOLD_CNT_W'(SPACE_HOLD_DEPTH)) begin
            cnt_nxt = '0;
            mid     = PH_OVERFLOW;
          end else begin
            cmd.hold_v   = 1'b1;
            cmd.hold_idx = cnt_r[HOLD_IDX_W-1:0];
            cnt_nxt      = cnt_r + HOLD_CNT_W'(1);
          end
        end
      end

      if (b == CH_LF || in_end_of_input) begin
        unique case (mid) inside
          PH_SECTION_DONE:                st = ST_SECTION;
          PH_VALUE_START, PH_VALUE:       st = ST_KEY_VAL;
          PH_SECTION, PH_KEY, PH_GARBAGE: st = ST_GARBAGE;
          PH_OVERFLOW:                    st = ST_OVERFLOW;
          default:                        st = ST_SKIPPED;
        endcase
        ln           = (line_r == '1) ? line_r : line_r + LINE_NUMBER_BITS'(1);
        cmd.status_v = 1'b1;
        cmd.status   = st;
        cmd.line_num = ln;
        cnt_nxt      = '0;
        phase_nxt    = (st == ST_GARBAGE && stop_on_garbage) ? PH_HALTED : PH_LINE_START;
      end else begin
        phase_nxt = mid;
      end

      // end of input restarts numbering for the next stream
      line_nxt = in_end_of_input ? '0 : ln;
    end
  end

  assign push     = accept && (cmd.hold_v || cmd.flush_n != '0 || cmd.emit_v || cmd.status_v);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE_START;
      cnt_r   <= '0;
      line_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

>>> rtl/ilt_cmd_fifo.sv
// Command queue between the front end and the result sequencer.
module ilt_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ilt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output ilt_pkg::cmd_t head,
  output logic          empty
);
  import ilt_pkg::*;

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r;

  assign full  = count_r == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (FIFO_PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (FIFO_PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("command pushed into full queue");

endmodule

>>> rtl/ilt_back.sv
// Back end: holds whitespace, expands commands into results, drives the output register.
module ilt_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fifo_empty,
  input  ilt_pkg::cmd_t                        fifo_head,
  output logic                                 fifo_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ilt_pkg::kind_t                       out_kind,
  output logic [7:0]                           out_data_byte,
  output ilt_pkg::status_t                     out_line_status,
  output logic [ilt_pkg::LINE_NUMBER_BITS-1:0] out_line_number,
  output logic                                 out_last_of_run
);
  import ilt_pkg::*;

  logic [7:0]                  hold_buf_r [SPACE_HOLD_DEPTH];
  cmd_t                        cur_r, cur_nxt;
  logic                        cur_v_r, cur_v_nxt;
  logic [HOLD_CNT_W-1:0]       idx_r, idx_nxt;

  logic                        out_valid_r;
  kind_t                       out_kind_r;
  logic [7:0]                  out_data_r;
  status_t                     out_status_r;
  logic [LINE_NUMBER_BITS-1:0] out_line_r;
  logic                        out_last_r;

  logic                        can_load;
  logic                        in_flush;
  logic                        step;
  logic                        done;
  kind_t                       res_kind;
  logic [7:0]                  res_data;
  status_t                     res_status;
  logic [LINE_NUMBER_BITS-1:0] res_line;
  logic                        res_last;

  assign can_load = !out_valid_r || out_ready;
  assign in_flush = idx_r < cur_r.flush_n;
  assign step     = cur_v_r && can_load;
  assign done     = step && res_last;
  assign fifo_pop = !fifo_empty && (!cur_v_r || done);

  always_comb begin
    res_kind   = KIND_STATUS;
    res_data   = '0;
    res_status = ST_SKIPPED;
    res_line   = '0;
    res_last   = 1'b1;
    if (in_flush) begin
      res_kind = cur_r.flush_kind;
      res_data = hold_buf_r[idx_r[HOLD_IDX_W-1:0]];
      res_last = (idx_r + HOLD_CNT_W'(1)) == cur_r.flush_n &&
                 !cur_r.emit_v && !cur_r.status_v;
    end else if (cur_r.emit_v) begin
      res_kind = cur_r.emit_kind;
      res_data = cur_r.text;
      res_last = !cur_r.status_v;
    end else begin
      res_status = cur_r.status;
      res_line   = cur_r.line_num;
    end
  end

  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (step) begin
      if (in_flush) begin
        idx_nxt = idx_r + HOLD_CNT_W'(1);
      end else if (cur_r.emit_v) begin
        cur_nxt.emit_v = 1'b0;
      end
    end
    if (done) begin
      cur_v_nxt = 1'b0;
      idx_nxt   = '0;
    end
    // hold-only commands finish at pop and never occupy the sequencer
    if (fifo_pop) begin
      cur_nxt   = fifo_head;
      cur_v_nxt = fifo_head.flush_n != '0 || fifo_head.emit_v || fifo_head.status_v;
      idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (step) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_line_r   <= res_line;
      out_last_r   <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop && fifo_head.hold_v) hold_buf_r[fifo_head.hold_idx] <= fifo_head.text;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_data_byte   = out_data_r;
  assign out_line_status = out_status_r;
  assign out_line_number = out_line_r;
  assign out_last_of_run = out_last_r;

  a_cur_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (cur_r.flush_n != '0 || cur_r.emit_v || cur_r.status_v))
    else $error("sequencer busy with an empty command");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> idx_r <= cur_r.flush_n)
    else $error("flush index ran past held count");

  a_status_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_STATUS) |-> out_last_r)
    else $error("line status not marked last of run");

endmodule

>>> tb/sv/ini_line_tokenizer_top_test.sv
// Self-checking testbench for the INI line tokenizer: random text lines against a tokenizer model.
`timescale 1ns / 100ps

module ini_line_tokenizer_top_test;
  import ilt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_RBR    = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [CFG_ADDR_W-1:0] ADDR_STOP_ON_GARBAGE = {CFG_IDX_STOP_ON_GARBAGE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED        = 3'd4;

  localparam logic [LINE_NUMBER_BITS-1:0] LINE_NO_MAX = {LINE_NUMBER_BITS{1'b1}};

  typedef enum logic [3:0] {
    LN_START, LN_SKIP, LN_SECTION, LN_SECTION_DONE, LN_KEY,
    LN_VALUE_START, LN_VALUE, LN_GARBAGE, LN_OVERFLOW, LN_HALTED
  } line_state_t;

  typedef enum {PICK_KEY, PICK_NAME, PICK_VALUE} pick_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } text_item_t;

  typedef struct packed {
    kind_t                       kind;
    logic [7:0]                  data;
    status_t                     status;
    logic [LINE_NUMBER_BITS-1:0] line;
    logic                        last;
  } token_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_text_byte = 8'h00;
  logic                        in_end_of_input = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  out_kind;
  logic [7:0]                  out_data_byte;
  logic [2:0]                  out_line_status;
  logic [LINE_NUMBER_BITS-1:0] out_line_number;
  logic                        out_last_of_run;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]       cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]       cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]       cfg_prdata;
  logic                        cfg_pready;

  ini_line_tokenizer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_input(in_end_of_input),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_line_status(out_line_status),
    .out_line_number(out_line_number),
    .out_last_of_run(out_last_of_run),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_item_t text_q[$];
  token_t     want_tokens[$];
  logic [7:0] line_buf[$];

  int  errors = 0;
  int  cycles = 0;
  int  bytes_sent = 0;
  int  tokens_checked = 0;
  int  status_seen[5] = '{0, 0, 0, 0, 0};
  int  in_gap = 0;
  int  out_gap = 0;
  bit  no_idle = 1'b0;
  bit  calm = 1'b0;

  // Tokenizer model state
  line_state_t                 ln_state;
  logic [7:0]                  held_ws[SPACE_HOLD_DEPTH];
  int                          held_n;
  logic [LINE_NUMBER_BITS-1:0] line_no;
  logic                        stop_garbage;

  task automatic log_error(input string msg);
    errors++;
    $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  function automatic bit is_space(input logic [7:0] b);
    return b == CH_SP || b == CH_HT || b == CH_VT || b == CH_FF || b == CH_CR;
  endfunction

  function automatic bit is_key_junk(input logic [7:0] b);
    return b == CH_COMMA || b == CH_BAR || b == CH_SLASH || b == CH_BSLASH;
  endfunction

  function automatic void tok_reset();
    ln_state     = LN_START;
    held_n       = 0;
    line_no      = '0;
    stop_garbage = 1'b1;
  endfunction

  function automatic void tok_emit(input kind_t k, input logic [7:0] d, input status_t s,
                                   input logic [LINE_NUMBER_BITS-1:0] n);
    token_t t;
    t.kind   = k;
    t.data   = d;
    t.status = s;
    t.line   = n;
    t.last   = 1'b0;
    want_tokens.push_back(t);
  endfunction

  function automatic void tok_flush(input kind_t k);
    for (int i = 0; i < held_n; i++) tok_emit(k, held_ws[i], ST_SKIPPED, '0);
    held_n = 0;
  endfunction

  // A whitespace byte beyond the hold depth drops the run and kills the line.
  function automatic void tok_hold(input logic [7:0] b);
    if (held_n >= SPACE_HOLD_DEPTH) begin
      held_n   = 0;
      ln_state = LN_OVERFLOW;
    end else begin
      held_ws[held_n] = b;
      held_n++;
    end
  endfunction

  function automatic void tok_end_line();
    status_t st;
    case (ln_state)
      LN_SECTION_DONE:          st = ST_SECTION;
      LN_VALUE_START, LN_VALUE: st = ST_KEY_VAL;
      LN_SECTION, LN_KEY, LN_GARBAGE: st = ST_GARBAGE;
      LN_OVERFLOW:              st = ST_OVERFLOW;
      default:                  st = ST_SKIPPED;
    endcase
    if (line_no != LINE_NO_MAX) line_no++;
    tok_emit(KIND_STATUS, 8'h00, st, line_no);
    held_n   = 0;
    ln_state = (st == ST_GARBAGE && stop_garbage) ? LN_HALTED : LN_START;
  endfunction

  function automatic void tok_text(input logic [7:0] b);
    case (ln_state)
      LN_START: begin
        if (!is_space(b)) begin
          if (b == CH_SEMI || b == CH_HASH) ln_state = LN_SKIP;
          else if (b == CH_LBR) ln_state = LN_SECTION;
          else if (b == CH_EQ) ln_state = LN_VALUE_START;
          else if (is_key_junk(b)) ln_state = LN_GARBAGE;
          else begin
            tok_emit(KIND_KEY, b, ST_SKIPPED, '0);
            ln_state = LN_KEY;
          end
        end
      end
      LN_SECTION: begin
        if (b == CH_RBR) ln_state = LN_SECTION_DONE;
        else tok_emit(KIND_SECTION, b, ST_SKIPPED, '0);
      end
      LN_KEY: begin
        if (b == CH_EQ) begin
          held_n   = 0;
          ln_state = LN_VALUE_START;
        end else if (is_key_junk(b)) begin
          held_n   = 0;
          ln_state = LN_GARBAGE;
        end else if (is_space(b)) begin
          tok_hold(b);
        end else begin
          tok_flush(KIND_KEY);
          tok_emit(KIND_KEY, b, ST_SKIPPED, '0);
        end
      end
      LN_VALUE_START: begin
        if (!is_space(b)) begin
          tok_emit(KIND_VALUE, b, ST_SKIPPED, '0);
          ln_state = LN_VALUE;
        end
      end
      LN_VALUE: begin
        if (is_space(b)) tok_hold(b);
        else begin
          tok_flush(KIND_VALUE);
          tok_emit(KIND_VALUE, b, ST_SKIPPED, '0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void tok_step(input logic [7:0] b, input logic eoi);
    int n0;
    n0 = want_tokens.size();
    if (ln_state != LN_HALTED) begin
      if (b == CH_LF) tok_end_line();
      else begin
        tok_text(b);
        if (eoi) tok_end_line();
      end
      if (eoi) line_no = '0;
      if (want_tokens.size() > n0) want_tokens[want_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  // Stimulus builders
  task automatic queue_byte(input logic [7:0] b, input logic eoi);
    text_item_t it;
    it.b   = b;
    it.eoi = eoi;
    text_q.push_back(it);
  endtask

  task automatic queue_str(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], eoi_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 4))
      0:       return CH_SP;
      1:       return CH_HT;
      2:       return CH_VT;
      3:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_junk();
    case ($urandom_range(0, 3))
      0:       return CH_COMMA;
      1:       return CH_BAR;
      2:       return CH_SLASH;
      default: return CH_BSLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_plain(input pick_t mode);
    logic [7:0] b;
    bit         ok;
    ok = 1'b0;
    b  = 8'h00;
    while (!ok) begin
      b  = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(97, 122));
      ok = !is_space(b) && b != CH_LF;
      if (mode == PICK_KEY && (b == CH_EQ || is_key_junk(b) || b == CH_SEMI ||
                               b == CH_HASH || b == CH_LBR)) ok = 1'b0;
      if (mode == PICK_NAME && b == CH_RBR) ok = 1'b0;
    end
    return b;
  endfunction

  // Mostly short runs; now and then one from two under to one past the hold depth.
  function automatic int ws_run();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(SPACE_HOLD_DEPTH - 2, SPACE_HOLD_DEPTH + 1)
                                       : $urandom_range(1, 3);
  endfunction

  task automatic add_ws(input int n);
    repeat (n) line_buf.push_back(pick_ws());
  endtask

  task automatic add_word(input pick_t mode, input int n);
    repeat (n) line_buf.push_back(pick_plain(mode));
  endtask

  task automatic add_key_value();
    add_ws($urandom_range(0, 2));
    add_word(PICK_KEY, $urandom_range(1, 4));
    if ($urandom_range(0, 1)) begin
      add_ws(ws_run());
      add_word(PICK_KEY, $urandom_range(1, 3));
    end
    add_ws($urandom_range(0, 2));
    line_buf.push_back(CH_EQ);
    add_ws($urandom_range(0, 2));
    add_word(PICK_VALUE, $urandom_range(0, 5));
    if ($urandom_range(0, 1)) begin
      add_ws(ws_run());
      add_word(PICK_VALUE, $urandom_range(1, 3));
    end
    add_ws($urandom_range(0, 2));
  endtask

  task automatic gen_line();
    bit eoi;
    line_buf.delete();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: add_key_value();
      8, 9, 10: begin
        add_ws($urandom_range(0, 1));
        line_buf.push_back(CH_LBR);
        add_word(PICK_NAME, $urandom_range(0, 5));
        if ($urandom_range(0, 5) != 0) begin
          line_buf.push_back(CH_RBR);
          add_word(PICK_VALUE, $urandom_range(0, 3));
        end
      end
      11, 12: begin
        line_buf.push_back($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
        add_word(PICK_VALUE, $urandom_range(0, 6));
      end
      13: add_ws($urandom_range(0, 3));
      14, 15: begin
        add_word(PICK_KEY, $urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
          line_buf.push_back(pick_junk());
          add_word(PICK_VALUE, $urandom_range(0, 3));
          line_buf.push_back(CH_EQ);
          add_word(PICK_VALUE, $urandom_range(0, 3));
        end
      end
      16: begin
        add_word(PICK_KEY, $urandom_range(1, 2));
        if ($urandom_range(0, 1)) begin
          line_buf.push_back(CH_EQ);
          add_word(PICK_VALUE, $urandom_range(1, 2));
        end
        add_ws($urandom_range(SPACE_HOLD_DEPTH + 1, SPACE_HOLD_DEPTH + 3));
        add_word(PICK_VALUE, $urandom_range(0, 4));
      end
      default: begin
        repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    // End the line with LF, or let end of input close it on its last byte.
    eoi = ($urandom_range(0, 7) == 0);
    if (!(eoi && line_buf.size() != 0 && $urandom_range(0, 1) == 1)) line_buf.push_back(CH_LF);
    for (int i = 0; i < line_buf.size(); i++) queue_byte(line_buf[i], eoi && (i == line_buf.size() - 1));
  endtask

  // Configuration port: setup phase, then access phase
  task automatic apb_xfer(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                          input logic [CFG_DATA_W-1:0] wdata, output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_stop_reg(input logic want);
    logic [CFG_DATA_W-1:0] rd;
    apb_xfer(1'b0, ADDR_STOP_ON_GARBAGE, '0, rd);
    if (rd[0] !== want) log_error($sformatf("stop_on_garbage reads %0b, want %0b", rd[0], want));
  endtask

  task automatic write_stop_reg(input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    apb_xfer(1'b1, ADDR_STOP_ON_GARBAGE, value, rd);
    stop_garbage = value[0];
    check_stop_reg(value[0]);
  endtask

  // Wait until every byte is taken and every token has come out, then let the pipe empty.
  task automatic settle();
    while (text_q.size() != 0 || in_valid || want_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Byte driver
  always @(posedge clk) begin : drive_text
    text_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        tok_step(in_text_byte, in_end_of_input);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!no_idle && !calm && $urandom_range(0, 6) == 0) begin
          in_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          item = text_q.pop_front();
          in_valid        <= 1'b1;
          in_text_byte    <= item.b;
          in_end_of_input <= item.eoi;
        end
      end
    end
  end

  // Token monitor
  always @(posedge clk) begin : watch_tokens
    token_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_tokens.size() == 0) begin
          log_error($sformatf("unexpected token kind %0d data %02h status %0d line %0d last %0b",
                              out_kind, out_data_byte, out_line_status, out_line_number,
                              out_last_of_run));
        end else begin
          w = want_tokens.pop_front();
          tokens_checked++;
          if (w.kind == KIND_STATUS && w.status <= ST_OVERFLOW) status_seen[w.status]++;
          if (out_kind !== w.kind || out_data_byte !== w.data || out_line_status !== w.status ||
              out_line_number !== w.line || out_last_of_run !== w.last)
            log_error($sformatf("got k%0d d%02h s%0d n%0d l%0b, want k%0d d%02h s%0d n%0d l%0b",
                                out_kind, out_data_byte, out_line_status, out_line_number,
                                out_last_of_run, w.kind, w.data, w.status, w.line, w.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!no_idle && !calm && $urandom_range(0, 6) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles % 100 == 0) calm = ($urandom_range(0, 2) == 0);
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d tokens outstanding", cycles, want_tokens.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] rd;
    int                    base;
    tok_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_stop_reg(1'b1);
    apb_xfer(1'b1, ADDR_UNMAPPED, '1, rd);
    check_stop_reg(1'b1);
    // Only bit 0 counts; the other bits set here must not matter.
    write_stop_reg(32'hFFFF_FFFE);

    // Directed: leading blank, section, comment, unclosed section, junk in key,
    // keyless value with byte 0xFF, and a full hold buffer flushed by a final byte.
    queue_str("\t[s]\n", 1'b0);
    queue_str("#\n", 1'b0);
    queue_str("[x\n", 1'b0);
    queue_str("k|\n", 1'b0);
    queue_byte(CH_EQ, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte("k", 1'b0);
    repeat (SPACE_HOLD_DEPTH) queue_byte(CH_SP, 1'b0);
    queue_byte("v", 1'b1);

    base = text_q.size();
    while (text_q.size() - base < 255) gen_line();
    settle();

    // Last part: halting on garbage, no idling on either side.
    write_stop_reg(32'h0000_0001);
    no_idle = 1'b1;
    queue_str("a = 1\n", 1'b0);
    queue_str("[t]\n", 1'b0);
    queue_str("bad\n", 1'b0);
    queue_str("z = 2\n", 1'b0);
    queue_str("q", 1'b1);
    settle();

    if (want_tokens.size() != 0) log_error($sformatf("%0d tokens never came", want_tokens.size()));
    $display("Sent %0d text bytes, checked %0d tokens in %0d cycles.", bytes_sent,
             tokens_checked, cycles);
    $display("Line endings seen: skipped %0d, section %0d, key/value %0d, garbage %0d, overflow %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
